>>> sv/minimal_standard_lcg_stream_macros.svh
// assertion macros for the lcg stream checker
`ifndef MINIMAL_STANDARD_LCG_STREAM_MACROS_SVH
`define MINIMAL_STANDARD_LCG_STREAM_MACROS_SVH

// same-cycle implication
`define MSLCG_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSLCG_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mslcg_pkg.sv
package mslcg_pkg;

	localparam int unsigned STATE_W    = 31;
	localparam int unsigned DIM_W      = 7;
	localparam int unsigned PATHS_W    = 16;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned JUMP_W     = PATHS_W + DIM_W;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned CNT_W      = $clog2(STATE_W + 1);

	localparam int unsigned MAX_DIM_DEF = 64;

	localparam logic [STATE_W-1:0] LCG_MOD      = 31'h7FFF_FFFF;
	localparam logic [STATE_W-1:0] LCG_MUL      = 31'd16807;
	localparam int unsigned        LCG_MUL_BITS = 15;
	localparam logic [STATE_W-1:0] LCG_MUL_ALIGNED = LCG_MUL << (STATE_W - LCG_MUL_BITS);
	localparam logic [CNT_W-1:0]   MUL_CNT_STEP = CNT_W'(LCG_MUL_BITS);
	localparam logic [CNT_W-1:0]   MUL_CNT_FULL = CNT_W'(STATE_W);

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SEED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM  = 8'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_EMIT,
		S_JCHK,
		S_JMUL,
		S_JSQR
	} state_t;

endpackage

>>> sv/mslcg_if.sv
interface mslcg_req_if;
	logic                         valid;
	logic                         ready;
	logic [mslcg_pkg::CMD_W-1:0]   cmd;
	logic [mslcg_pkg::PATHS_W-1:0] skip_paths;

	modport source (output valid, output cmd, output skip_paths, input ready);
	modport sink   (input valid, input cmd, input skip_paths, output ready);
endinterface

interface mslcg_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mslcg_pkg::STATE_W-1:0] sample;
	logic                         last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mslcg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mslcg_pkg::CFG_IDX_W-1:0]  index;
	logic [mslcg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/minimal_standard_lcg_stream.sv
// draw: each sample of the vector runs the 15 multiplier bits of 16807 through the serial unit
// and is then registered onto the output, where it is held while the receiver stalls
// skip: square and multiply over skip_paths*dimensionality, a square for each bit and a product
// for each set bit, on the one-bit-a-cycle modular multiplier (31 bits per square or product)
// seed reload and unused commands leave the block idle; configuration words take effect at once
// arst_n clears the sequencer; seed, dimensionality and state all come out of reset as one
module minimal_standard_lcg_stream #(
	parameter int unsigned MAX_DIM = mslcg_pkg::MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mslcg_cfg_if.sink         cfg,
	mslcg_req_if.sink         req,
	mslcg_rsp_if.source       rsp
);

	localparam int unsigned DCW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	mslcg_pkg::state_t state_q, state_d;

	logic [mslcg_pkg::STATE_W-1:0] seed_q;
	logic [mslcg_pkg::DIM_W-1:0]   dim_q;
	logic [mslcg_pkg::STATE_W-1:0] cur_q;
	logic [mslcg_pkg::STATE_W-1:0] base_q;
	logic [mslcg_pkg::JUMP_W-1:0]  jump_q;
	logic [DCW-1:0]                draw_cnt_q;

	logic [mslcg_pkg::STATE_W-1:0] mul_a_q, mul_b_q, mul_acc_q;
	logic [mslcg_pkg::CNT_W-1:0]   mul_cnt_q;

	logic                          out_valid_q;
	logic [mslcg_pkg::STATE_W-1:0] out_sample_q;
	logic                          out_last_q;

	logic                          req_fire, cfg_fire, mul_busy, emit_ok, is_last;
	logic [mslcg_pkg::DIM_W-1:0]   dim_eff;
	logic [mslcg_pkg::JUMP_W-1:0]  jump_len;

	logic [mslcg_pkg::STATE_W-1:0] mul_rot, mul_nxt;
	logic [mslcg_pkg::STATE_W:0]   mul_sum, mul_red;

	logic mul_load, mul_load_full, mul_a_base, cur_from_mul, base_from_mul, emit;
	logic skip_load, reseed;

	function automatic logic [mslcg_pkg::STATE_W-1:0] sanitize(
		input logic [mslcg_pkg::STATE_W-1:0] s
	);
		if (s == '0 || s == mslcg_pkg::LCG_MOD) begin
			return mslcg_pkg::STATE_W'(1);
		end
		return s;
	endfunction

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == mslcg_pkg::S_IDLE);
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign req_fire  = req.valid && req.ready;

	assign rsp.valid  = out_valid_q;
	assign rsp.sample = out_sample_q;
	assign rsp.last   = out_last_q;

	always_comb begin
		if (dim_q == '0) begin
			dim_eff = mslcg_pkg::DIM_W'(1);
		end else if (dim_q > mslcg_pkg::DIM_W'(MAX_DIM)) begin
			dim_eff = mslcg_pkg::DIM_W'(MAX_DIM);
		end else begin
			dim_eff = dim_q;
		end
	end

	assign jump_len = mslcg_pkg::JUMP_W'(req.skip_paths) * mslcg_pkg::JUMP_W'(dim_eff);
	assign mul_busy = (mul_cnt_q != '0);
	assign emit_ok  = !out_valid_q || rsp.ready;
	assign is_last  = ((mslcg_pkg::DIM_W'(draw_cnt_q) + mslcg_pkg::DIM_W'(1)) == dim_eff);

	// one bit of the multiplier per cycle, doubling mod 2^31-1 is a rotate
	always_comb begin
		mul_rot = {mul_acc_q[mslcg_pkg::STATE_W-2:0], mul_acc_q[mslcg_pkg::STATE_W-1]};
		mul_sum = {1'b0, mul_rot} +
			(mul_b_q[mslcg_pkg::STATE_W-1] ? {1'b0, mul_a_q} : '0);
		mul_red = mul_sum - {1'b0, mslcg_pkg::LCG_MOD};
		mul_nxt = (mul_sum >= {1'b0, mslcg_pkg::LCG_MOD}) ?
			mul_red[mslcg_pkg::STATE_W-1:0] : mul_sum[mslcg_pkg::STATE_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mslcg_pkg::S_IDLE: begin
				if (req_fire) begin
					if (req.cmd == mslcg_pkg::CMD_DRAW) begin
						state_d = mslcg_pkg::S_STEP;
					end else if (req.cmd == mslcg_pkg::CMD_SKIP && jump_len != '0) begin
						state_d = mslcg_pkg::S_JCHK;
					end
				end
			end
			mslcg_pkg::S_STEP: begin
				if (!mul_busy) begin
					state_d = mslcg_pkg::S_EMIT;
				end
			end
			mslcg_pkg::S_EMIT: begin
				if (emit_ok) begin
					state_d = is_last ? mslcg_pkg::S_IDLE : mslcg_pkg::S_STEP;
				end
			end
			mslcg_pkg::S_JCHK: begin
				if (jump_q == '0) begin
					state_d = mslcg_pkg::S_IDLE;
				end else if (jump_q[0]) begin
					state_d = mslcg_pkg::S_JMUL;
				end else begin
					state_d = mslcg_pkg::S_JSQR;
				end
			end
			mslcg_pkg::S_JMUL: begin
				if (!mul_busy) begin
					state_d = mslcg_pkg::S_JSQR;
				end
			end
			mslcg_pkg::S_JSQR: begin
				if (!mul_busy) begin
					state_d = mslcg_pkg::S_JCHK;
				end
			end
			default: state_d = mslcg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mul_load      = 1'b0;
		mul_load_full = 1'b0;
		mul_a_base    = 1'b0;
		cur_from_mul  = 1'b0;
		base_from_mul = 1'b0;
		emit          = 1'b0;
		skip_load     = 1'b0;
		reseed        = 1'b0;
		case (state_q)
			mslcg_pkg::S_IDLE: begin
				if (req_fire) begin
					case (req.cmd)
						mslcg_pkg::CMD_DRAW:  mul_load = 1'b1;
						mslcg_pkg::CMD_RESET: reseed = 1'b1;
						mslcg_pkg::CMD_SKIP:  skip_load = 1'b1;
						default: ;
					endcase
				end
			end
			mslcg_pkg::S_STEP: begin
				cur_from_mul = !mul_busy;
			end
			mslcg_pkg::S_EMIT: begin
				emit     = emit_ok;
				mul_load = emit_ok && !is_last;
			end
			mslcg_pkg::S_JCHK: begin
				mul_load      = (jump_q != '0);
				mul_load_full = 1'b1;
				mul_a_base    = !jump_q[0];
			end
			mslcg_pkg::S_JMUL: begin
				cur_from_mul  = !mul_busy;
				mul_load      = !mul_busy;
				mul_load_full = 1'b1;
				mul_a_base    = 1'b1;
			end
			mslcg_pkg::S_JSQR: begin
				base_from_mul = !mul_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mslcg_pkg::S_IDLE;
			seed_q      <= mslcg_pkg::STATE_W'(1);
			dim_q       <= mslcg_pkg::DIM_W'(1);
			cur_q       <= mslcg_pkg::STATE_W'(1);
			jump_q      <= '0;
			draw_cnt_q  <= '0;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_fire && cfg.index == mslcg_pkg::REG_SEED) begin
				seed_q <= cfg.data;
				cur_q  <= sanitize(cfg.data);
			end else if (cfg_fire && cfg.index == mslcg_pkg::REG_DIM) begin
				dim_q <= cfg.data[mslcg_pkg::DIM_W-1:0];
				cur_q <= sanitize(seed_q);
			end else if (reseed) begin
				cur_q <= sanitize(seed_q);
			end else if (cur_from_mul) begin
				cur_q <= mul_acc_q;
			end

			if (skip_load) begin
				jump_q <= jump_len;
			end else if (base_from_mul) begin
				jump_q <= jump_q >> 1;
			end

			if (mul_load) begin
				mul_cnt_q <= mul_load_full ? mslcg_pkg::MUL_CNT_FULL : mslcg_pkg::MUL_CNT_STEP;
			end else if (mul_busy) begin
				mul_cnt_q <= mul_cnt_q - mslcg_pkg::CNT_W'(1);
			end

			if (emit) begin
				draw_cnt_q <= is_last ? '0 : draw_cnt_q + DCW'(1);
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skip_load) begin
			base_q <= mslcg_pkg::LCG_MUL;
		end else if (base_from_mul) begin
			base_q <= mul_acc_q;
		end

		if (mul_load) begin
			mul_acc_q <= '0;
			mul_a_q   <= mul_a_base ? base_q : (cur_from_mul ? mul_acc_q : cur_q);
			mul_b_q   <= mul_load_full ? base_q : mslcg_pkg::LCG_MUL_ALIGNED;
		end else if (mul_busy) begin
			mul_acc_q <= mul_nxt;
			mul_b_q   <= mul_b_q << 1;
		end

		if (emit) begin
			out_sample_q <= cur_q;
			out_last_q   <= is_last;
		end
	end

endmodule

>>> sv/mslcg_checker.sv
`include "minimal_standard_lcg_stream_macros.svh"

module mslcg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [mslcg_pkg::CMD_W-1:0]   req_cmd,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [mslcg_pkg::STATE_W-1:0] rsp_sample,
	input logic                          rsp_last
);

	`MSLCG_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample) && $stable(rsp_last), "stalled word changed")
	`MSLCG_ASSERT_NOW(a_sample_range, clk, arst_n, rsp_valid, rsp_sample != '0 && rsp_sample != mslcg_pkg::LCG_MOD, "sample outside generator range")
	`MSLCG_ASSERT_NOW(a_busy_mid_vector, clk, arst_n, rsp_valid && !rsp_last, !req_ready, "command taken in the middle of a vector")
	`MSLCG_ASSERT_NEXT(a_draw_busy, clk, arst_n, req_valid && req_ready && req_cmd == mslcg_pkg::CMD_DRAW, !req_ready, "draw did not start")

endmodule

bind minimal_standard_lcg_stream mslcg_checker u_mslcg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_cmd    (req.cmd),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_sample (rsp.sample),
	.rsp_last   (rsp.last)
);

>>> test/minimal_standard_lcg_stream_check.sv
module minimal_standard_lcg_stream_check (
	input  logic        clk,
	input  logic        arst_n,
	mslcg_cfg_if        cfg,
	mslcg_req_if        req,
	mslcg_rsp_if        rsp,
	output int unsigned errors,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import mslcg_pkg::*;

	localparam longint PRIME      = 64'd2147483647;
	localparam longint MULTIPLIER = 64'd16807;
	localparam longint SCHRAGE_Q  = 64'd127773;
	localparam longint SCHRAGE_R  = 64'd2836;

	typedef struct packed {
		logic [STATE_W-1:0] sample;
		logic               last;
	} variate_t;

	variate_t           variates_due[$];
	logic [STATE_W-1:0] seed_reg;
	logic [DIM_W-1:0]   dim_reg;
	logic [STATE_W-1:0] lcg_state;

	function automatic logic [STATE_W-1:0] clean_seed(logic [STATE_W-1:0] s);
		longint sv;
		sv = s;
		if (sv == 0 || sv == PRIME) begin
			return 1;
		end
		return s;
	endfunction

	function automatic int unsigned vector_len(logic [DIM_W-1:0] d);
		if (d == 0) begin
			return 1;
		end
		if (d > MAX_DIM_DEF) begin
			return MAX_DIM_DEF;
		end
		return d;
	endfunction

	function automatic logic [STATE_W-1:0] schrage_step(logic [STATE_W-1:0] x);
		longint xv;
		longint k;
		longint t;
		xv = x;
		k = xv / SCHRAGE_Q;
		t = MULTIPLIER * (xv - k * SCHRAGE_Q) - SCHRAGE_R * k;
		if (t < 0) begin
			t = t + PRIME;
		end
		return t[STATE_W-1:0];
	endfunction

	// x * 16807^n mod (2^31 - 1) by square and multiply
	function automatic logic [STATE_W-1:0] jump_ahead(logic [STATE_W-1:0] x,
			longint unsigned n);
		longint unsigned base;
		longint unsigned acc;
		base = MULTIPLIER;
		acc = 1;
		while (n != 0) begin
			if (n[0]) begin
				acc = (acc * base) % PRIME;
			end
			base = (base * base) % PRIME;
			n = n >> 1;
		end
		acc = (acc * x) % PRIME;
		return acc[STATE_W-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_variate();
		variate_t due;
		if (variates_due.size() == 0) begin
			report_mismatch($sformatf("unexpected word, sample %0d last %0b",
				rsp.sample, rsp.last));
		end else begin
			due = variates_due.pop_front();
			if (rsp.sample !== due.sample) begin
				report_mismatch($sformatf("sample %0d, expected %0d",
					rsp.sample, due.sample));
			end
			if (rsp.last !== due.last) begin
				report_mismatch($sformatf("last %0b, expected %0b on sample %0d",
					rsp.last, due.last, due.sample));
			end
		end
	endtask

	task automatic apply_register();
		case (cfg.index)
			REG_SEED: begin
				seed_reg = cfg.data;
				lcg_state = clean_seed(cfg.data);
			end
			REG_DIM: begin
				dim_reg = cfg.data[DIM_W-1:0];
				lcg_state = clean_seed(seed_reg);
			end
			default: begin
			end
		endcase
	endtask

	task automatic predict_command();
		int unsigned n;
		n = vector_len(dim_reg);
		case (req.cmd)
			CMD_DRAW: begin
				for (int unsigned i = 0; i < n; i++) begin
					lcg_state = schrage_step(lcg_state);
					variates_due.push_back('{sample: lcg_state, last: (i == n - 1)});
				end
			end
			CMD_RESET: begin
				lcg_state = clean_seed(seed_reg);
			end
			CMD_SKIP: begin
				lcg_state = jump_ahead(lcg_state, longint'(req.skip_paths) * n);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg = 1;
			dim_reg = 1;
			lcg_state = 1;
			variates_due.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				check_variate();
			end
			if (cfg.valid && cfg.ready) begin
				apply_register();
			end
			if (req.valid && req.ready) begin
				predict_command();
			end
		end
		outstanding = variates_due.size();
	end
endmodule

>>> test/minimal_standard_lcg_stream_test.sv
module minimal_standard_lcg_stream_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mslcg_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_CYCLES   = 4000;
	localparam int SQUEEZE_CYCLES = 3000;
	localparam longint TIMEOUT_NS = 64'd200_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	bit          steady;
	bit          squeeze;
	bit          hold_rsp;
	int unsigned errors;
	int unsigned outstanding;

	mslcg_cfg_if cfg_bus();
	mslcg_req_if req_bus();
	mslcg_rsp_if rsp_bus();

	minimal_standard_lcg_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	minimal_standard_lcg_stream_check lcg_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_bus),
		.req         (req_bus),
		.rsp         (rsp_bus),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_cycles();
		int unsigned roll;
		if (steady) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			return 0;
		end
		if (roll < 88) begin
			return $urandom_range(1, 3);
		end
		if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// receiver side
	initial begin
		int unsigned idle_left;
		idle_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_bus.ready <= 1'b0;
			end else if (idle_left > 0) begin
				rsp_bus.ready <= 1'b0;
				idle_left--;
			end else begin
				rsp_bus.ready <= 1'b1;
				idle_left = gap_cycles();
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		hold_rsp = 1'b0;
		wait (squeeze);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (SQUEEZE_CYCLES) @(posedge clk);
		hold_rsp = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PATHS_W-1:0] paths);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.cmd <= cmd;
		req_bus.skip_paths <= paths;
		do @(posedge clk); while (!req_bus.ready);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		req_bus.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic send_random_command();
		int unsigned pick;
		logic [PATHS_W-1:0] paths;
		pick = $urandom_range(0, 99);
		paths = PATHS_W'($urandom);
		if (pick < 60) begin
			send_command(CMD_DRAW, paths);
		end else if (pick < 72) begin
			send_command(CMD_RESET, paths);
		end else if (pick < 90) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				paths = PATHS_W'($urandom_range(0, 20));
			end else if (pick >= 95) begin
				paths = '1;
			end
			send_command(CMD_SKIP, paths);
		end else begin
			send_command(CMD_UNUSED, paths);
		end
	endtask

	task automatic random_phase(input logic [STATE_W-1:0] seed, input logic [DIM_W-1:0] dim,
			input int items, input bit calm, input bit tight);
		wait_quiet();
		if ($urandom_range(0, 1)) begin
			write_register(REG_SEED, seed);
			write_register(REG_DIM, CFG_DATA_W'(dim));
		end else begin
			write_register(REG_DIM, CFG_DATA_W'(dim));
			write_register(REG_SEED, seed);
		end
		write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
		steady = calm;
		if (tight) begin
			squeeze = 1'b1;
		end
		repeat (items) send_random_command();
		steady = 1'b0;
	endtask

	initial begin
		req_bus.valid = 1'b0;
		req_bus.cmd = CMD_DRAW;
		req_bus.skip_paths = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_SEED;
		cfg_bus.data = '0;
		steady = 1'b0;
		squeeze = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset values, zero skip, unused command, seed reload
		send_command(CMD_DRAW, '1);
		send_command(CMD_SKIP, '0);
		send_command(CMD_DRAW, '0);
		send_command(CMD_UNUSED, '1);
		send_command(CMD_DRAW, '0);
		send_command(CMD_RESET, '0);
		send_command(CMD_DRAW, '0);

		// seed of zero, seed equal to the modulus, largest seed, unknown registers
		wait_quiet();
		write_register(REG_SEED, '0);
		send_command(CMD_DRAW, '0);
		wait_quiet();
		write_register(REG_SEED, '1);
		send_command(CMD_DRAW, '0);
		wait_quiet();
		write_register(REG_SEED, 31'h7FFF_FFFE);
		write_register('1, '1);
		write_register(8'd2, CFG_DATA_W'($urandom));
		send_command(CMD_DRAW, '0);

		// dimensionality of zero, above the maximum, and at it
		wait_quiet();
		write_register(REG_DIM, '0);
		send_command(CMD_DRAW, '0);
		wait_quiet();
		write_register(REG_DIM, '1);
		send_command(CMD_DRAW, '0);
		send_command(CMD_SKIP, '1);
		send_command(CMD_DRAW, '0);
		send_command(CMD_SKIP, 16'd1);
		send_command(CMD_RESET, '0);
		send_command(CMD_DRAW, '0);
		wait_quiet();
		write_register(REG_DIM, CFG_DATA_W'(MAX_DIM_DEF));
		send_command(CMD_DRAW, '0);
		send_command(CMD_SKIP, PATHS_W'($urandom));
		send_command(CMD_DRAW, '0);

		random_phase(STATE_W'($urandom), 7'd1, 65, 1'b0, 1'b0);
		random_phase(STATE_W'($urandom), 7'd3, 60, 1'b0, 1'b1);
		random_phase(31'h7FFF_FFFE, DIM_W'(MAX_DIM_DEF), 25, 1'b0, 1'b0);
		random_phase(STATE_W'($urandom), DIM_W'($urandom_range(1, 8)), 65, 1'b1, 1'b0);
		random_phase('0, '0, 45, 1'b0, 1'b0);
		random_phase(STATE_W'($urandom), '1, 20, 1'b1, 1'b0);
		random_phase(STATE_W'($urandom), DIM_W'($urandom_range(1, 16)), 30, 1'b0, 1'b0);

		wait_quiet();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
